### rtl/core/memory_pattern_test_sequencer_macros.svh
// Assertion macros used by the memory pattern test sequencer checker
`ifndef MEMORY_PATTERN_TEST_SEQUENCER_MACROS_SVH
`define MEMORY_PATTERN_TEST_SEQUENCER_MACROS_SVH

// Same-cycle implication under clock and active-low reset
`define MPTS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under clock and active-low reset
`define MPTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/mpts_pkg.sv
// Types, codes and pattern constants of the memory pattern test sequencer
`timescale 1ns / 1ps
package mpts_pkg;

	typedef enum logic [1:0] {
		KIND_WRITE   = 2'd0,
		KIND_READ    = 2'd1,
		KIND_VERDICT = 2'd2
	} kind_t;

	localparam logic [2:0]  NUM_PHASES   = 3'd5;
	localparam logic [2:0]  PHASE_HASH   = 3'd4;
	localparam logic [31:0] HASH_MULT    = 32'h9e37_79b1;
	localparam logic [31:0] HASH_XOR     = 32'ha5c3_5a7d;
	localparam logic [31:0] WORD_ZEROS   = 32'h0000_0000;
	localparam logic [31:0] WORD_ONES    = 32'hffff_ffff;
	localparam logic [31:0] WORD_ALT_A   = 32'haaaa_aaaa;
	localparam logic [31:0] WORD_ALT_5   = 32'h5555_5555;
	localparam logic [31:0] MIN_BYTES    = 32'd4;

	typedef struct packed {
		logic        opcode;
		logic [31:0] base_address;
		logic [31:0] byte_count;
		logic [31:0] read_data;
	} req_t;

	typedef struct packed {
		kind_t       access_kind;
		logic [31:0] access_address;
		logic [31:0] write_data;
		logic        test_passed;
	} res_t;

	function automatic logic [31:0] fixed_word(input logic [1:0] phase);
		logic [31:0] w;
		case (phase)
			2'd0: w = WORD_ZEROS;
			2'd1: w = WORD_ONES;
			2'd2: w = WORD_ALT_A;
			2'd3: w = WORD_ALT_5;
			default: w = WORD_ZEROS;
		endcase
		return w;
	endfunction

	// prod holds index * HASH_MULT modulo 2^32
	function automatic logic [31:0] pattern_word(input logic [2:0] phase,
			input logic [31:0] prod);
		logic [31:0] w;
		if (phase < PHASE_HASH) begin
			w = fixed_word(phase[1:0]);
		end else begin
			w = prod ^ HASH_XOR;
		end
		return w;
	endfunction

endpackage

### rtl/core/mpts_in_stage.sv
// Input register stage: captures one item and holds it until the engine takes it
`timescale 1ns / 1ps
module mpts_in_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  mpts_pkg::req_t req,
	input  logic          take,
	output logic          valid_s1,
	output mpts_pkg::req_t req_s1
);
	import mpts_pkg::*;

	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1 <= req;
		end
	end

endmodule

### rtl/core/mpts_engine.sv
// Test sequencing engine: phase, sweep and index state with next-access logic
`timescale 1ns / 1ps
module mpts_engine (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  mpts_pkg::req_t req,
	output logic           res_valid,
	output mpts_pkg::res_t res
);
	import mpts_pkg::*;

	logic        running_q;
	logic [2:0]  phase_q;
	logic        reading_q;
	logic [29:0] index_q;
	logic [29:0] total_q;
	logic [31:0] base_q;
	logic [31:0] prod_q;

	logic        running_d;
	logic [2:0]  phase_d;
	logic        reading_d;
	logic [29:0] index_d;
	logic [29:0] total_d;
	logic [31:0] base_d;
	logic [31:0] prod_d;

	logic        emit_access;
	logic        emit_verdict;
	logic        verdict_pass;
	logic [31:0] expected;
	logic [29:0] index_inc;
	logic [2:0]  phase_inc;

	assign expected  = pattern_word(phase_q, prod_q);
	assign index_inc = index_q + 30'd1;
	assign phase_inc = phase_q + 3'd1;

	always_comb begin
		running_d    = running_q;
		phase_d      = phase_q;
		reading_d    = reading_q;
		index_d      = index_q;
		total_d      = total_q;
		base_d       = base_q;
		prod_d       = prod_q;
		emit_access  = 1'b0;
		emit_verdict = 1'b0;
		verdict_pass = 1'b0;
		if (!req.opcode) begin
			if (req.base_address[1:0] != 2'b00 || req.byte_count < MIN_BYTES) begin
				running_d    = 1'b0;
				emit_verdict = 1'b1;
			end else begin
				running_d   = 1'b1;
				phase_d     = 3'd0;
				reading_d   = 1'b0;
				index_d     = 30'd0;
				prod_d      = 32'd0;
				total_d     = req.byte_count[31:2];
				base_d      = req.base_address;
				emit_access = 1'b1;
			end
		end else if (running_q) begin
			if (reading_q && req.read_data != expected) begin
				running_d    = 1'b0;
				emit_verdict = 1'b1;
			end else begin
				index_d     = index_inc;
				prod_d      = prod_q + HASH_MULT;
				emit_access = 1'b1;
				if (index_inc >= total_q) begin
					index_d = 30'd0;
					prod_d  = 32'd0;
					if (!reading_q) begin
						reading_d = 1'b1;
					end else begin
						reading_d = 1'b0;
						phase_d   = phase_inc;
						if (phase_inc >= NUM_PHASES) begin
							running_d    = 1'b0;
							emit_access  = 1'b0;
							emit_verdict = 1'b1;
							verdict_pass = 1'b1;
						end
					end
				end
			end
		end
	end

	always_comb begin
		res = '0;
		res.access_kind = KIND_WRITE;
		if (emit_verdict) begin
			res.access_kind = KIND_VERDICT;
			res.test_passed = verdict_pass;
		end else if (emit_access) begin
			res.access_kind    = reading_d ? KIND_READ : KIND_WRITE;
			res.access_address = base_d + {index_d, 2'b00};
			res.write_data     = reading_d ? 32'd0 : pattern_word(phase_d, prod_d);
		end
	end

	assign res_valid = emit_access || emit_verdict;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			phase_q   <= 3'd0;
			reading_q <= 1'b0;
			index_q   <= 30'd0;
			total_q   <= 30'd0;
			base_q    <= 32'd0;
			prod_q    <= 32'd0;
		end else if (fire) begin
			running_q <= running_d;
			phase_q   <= phase_d;
			reading_q <= reading_d;
			index_q   <= index_d;
			total_q   <= total_d;
			base_q    <= base_d;
			prod_q    <= prod_d;
		end
	end

endmodule

### rtl/core/mpts_out_stage.sv
// Result register: holds one result item until the downstream side takes it
`timescale 1ns / 1ps
module mpts_out_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  mpts_pkg::res_t res,
	output logic           slot_free,
	output logic           m_tvalid,
	input  logic           m_tready,
	output mpts_pkg::res_t res_q
);
	import mpts_pkg::*;

	logic valid_q;

	assign slot_free = !valid_q || m_tready;
	assign m_tvalid  = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

### rtl/core/memory_pattern_test_sequencer.sv
// Top level of the memory pattern test sequencer
//
// Drives a five-phase write-then-read-back test over a word region of an external
// memory. Each accepted item gives at most one result item: a start gives the first
// write request or an immediate fail verdict, each advance gives the next read or
// write request, or the verdict. One item is taken every cycle while the result
// register is empty or the master side takes its item. An accepted item waits in the
// input register until the result register has room; the engine then updates its
// state and loads any result item into the result register, which offers it on the
// master side. The rate is set by the update of the phase, sweep and index
// registers; the phase-four pattern is stepped by one addition per word, so no
// multiplier sits in that loop. When both the input register and the result
// register hold items, s_tready follows m_tready combinationally.
`timescale 1ns / 1ps
module memory_pattern_test_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,  // base_address, byte_count, read_data
	input  logic        s_tuser,  // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // access_address, write_data, test_passed, 7 zero bits
	output logic [1:0]  m_tuser   // access_kind
);
	import mpts_pkg::*;

	req_t req;
	req_t req_s1;
	res_t res;
	res_t res_q;
	logic valid_s1;
	logic slot_free;
	logic fire;
	logic res_valid;

	assign req.opcode       = s_tuser;
	assign req.base_address = s_tdata[31:0];
	assign req.byte_count   = s_tdata[63:32];
	assign req.read_data    = s_tdata[95:64];

	assign fire = valid_s1 && slot_free;

	mpts_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.req      (req),
		.take     (slot_free),
		.valid_s1 (valid_s1),
		.req_s1   (req_s1)
	);

	mpts_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.req       (req_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	mpts_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire && res_valid),
		.res       (res),
		.slot_free (slot_free),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.res_q     (res_q)
	);

	assign m_tdata = {7'd0, res_q.test_passed, res_q.write_data, res_q.access_address};
	assign m_tuser = res_q.access_kind;

endmodule

### rtl/core/mpts_checker.sv
// Port-level checker for the memory pattern test sequencer, with its bind
`timescale 1ns / 1ps
`include "memory_pattern_test_sequencer_macros.svh"
module mpts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata,
	input logic [1:0]  m_tuser
);
	import mpts_pkg::*;

	`MPTS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid, "result item dropped while stalled")
	`MPTS_ASSERT_NEXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "stalled result item changed")
	`MPTS_ASSERT_SAME(a_access_no_pass, clk, arst_n, m_tvalid && m_tuser != KIND_VERDICT, m_tdata[64] == 1'b0, "pass flag set on an access")
	`MPTS_ASSERT_SAME(a_verdict_clean, clk, arst_n, m_tvalid && m_tuser == KIND_VERDICT, m_tdata[63:0] == 64'd0, "verdict carries address or data")
	`MPTS_ASSERT_SAME(a_read_no_data, clk, arst_n, m_tvalid && m_tuser == KIND_READ, m_tdata[63:32] == 32'd0, "read request carries write data")

endmodule

bind memory_pattern_test_sequencer mpts_checker u_mpts_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

### tb/memory_pattern_test_sequencer_tb.sv
// Self-checking stream testbench for the memory pattern test sequencer
`timescale 1ns / 1ps
module memory_pattern_test_sequencer_tb;
	import mpts_pkg::*;

	localparam logic OP_START   = 1'b0;
	localparam logic OP_ADVANCE = 1'b1;
	localparam int   ITEM_GOAL   = 1050;
	localparam int   QUIET_LIMIT = 2000;
	localparam int   HOLD_CYCLES = 80;
	localparam int   HOLD_AT     = 300;
	localparam int   CALM_FROM   = 500;
	localparam int   CALM_TO     = 650;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;  // base_address, byte_count, read_data
	logic        s_tuser = 1'b0;  // opcode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;  // access_address, write_data, test_passed, 7 zero bits
	logic [1:0]  m_tuser;  // access_kind

	req_t pending_items[$];
	res_t expected_accesses[$];

	int   planned = 0;
	int   items_in = 0;
	int   quiet_cycles = 0;
	int   error_count = 0;
	logic in_taken = 1'b0;
	int   hold_left = 0;
	logic holdoff_done = 1'b0;
	logic calm;

	logic        run_active = 1'b0;
	logic [2:0]  cur_phase = '0;
	logic        in_read_sweep = 1'b0;
	logic [29:0] widx = '0;
	logic [29:0] wtotal = '0;
	logic [31:0] rbase = '0;

	memory_pattern_test_sequencer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	assign calm = (items_in >= CALM_FROM) && (items_in < CALM_TO);

	function automatic logic [31:0] fill_word(input logic [2:0] ph, input logic [29:0] idx);
		logic [31:0] w;
		case (ph)
			3'd0: w = WORD_ZEROS;
			3'd1: w = WORD_ONES;
			3'd2: w = WORD_ALT_A;
			3'd3: w = WORD_ALT_5;
			default: w = ({2'b00, idx} * HASH_MULT) ^ HASH_XOR;
		endcase
		return w;
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
		error_count++;
	endtask

	task automatic step_sequencer(input logic op, input logic [95:0] d);
		logic [31:0] base, bytes, rdata;
		logic        emit, verdict, passed;
		res_t        r;
		base = d[31:0];
		bytes = d[63:32];
		rdata = d[95:64];
		emit = 1'b1;
		verdict = 1'b0;
		passed = 1'b0;
		if (op == OP_START) begin
			if (base[1:0] != 2'b00 || bytes < MIN_BYTES) begin
				verdict = 1'b1;
			end else begin
				run_active = 1'b1;
				cur_phase = '0;
				in_read_sweep = 1'b0;
				widx = '0;
				wtotal = bytes[31:2];
				rbase = base;
			end
		end else if (!run_active) begin
			emit = 1'b0;
		end else if (in_read_sweep && rdata != fill_word(cur_phase, widx)) begin
			verdict = 1'b1;
		end else begin
			widx = widx + 1'b1;
			if (widx >= wtotal) begin
				widx = '0;
				if (!in_read_sweep) begin
					in_read_sweep = 1'b1;
				end else begin
					in_read_sweep = 1'b0;
					cur_phase = cur_phase + 1'b1;
					if (cur_phase >= NUM_PHASES) begin
						verdict = 1'b1;
						passed = 1'b1;
					end
				end
			end
		end
		if (emit) begin
			r = '0;
			if (verdict) begin
				run_active = 1'b0;
				r.access_kind = KIND_VERDICT;
				r.test_passed = passed;
			end else begin
				r.access_kind = in_read_sweep ? KIND_READ : KIND_WRITE;
				r.access_address = rbase + {widx, 2'b00};
				r.write_data = in_read_sweep ? 32'd0 : fill_word(cur_phase, widx);
			end
			expected_accesses.push_back(r);
		end
	endtask

	task automatic queue_item(input logic op, input logic [31:0] base,
			input logic [31:0] bytes, input logic [31:0] rdata, input bit counts = 1'b1);
		req_t it;
		it.opcode = op;
		it.base_address = base;
		it.byte_count = bytes;
		it.read_data = rdata;
		pending_items.push_back(it);
		if (counts) begin
			planned++;
		end
	endtask

	// start, then one advance per issued access; corrupt one read or stop early on request
	task automatic plan_test(input logic [31:0] base, input logic [31:0] bytes,
			input int fail_at, input int stop_after);
		int unsigned words;
		int          issued;
		int          reads_seen;
		logic [31:0] good;
		words = bytes >> 2;
		issued = 0;
		reads_seen = 0;
		queue_item(OP_START, base, bytes, $urandom);
		for (int p = 0; p < 5; p++) begin
			for (int sw = 0; sw < 2; sw++) begin
				for (int unsigned i = 0; i < words; i++) begin
					if (issued == stop_after) begin
						return;
					end
					issued++;
					if (sw == 0) begin
						queue_item(OP_ADVANCE, $urandom, $urandom, $urandom);
					end else begin
						good = fill_word(3'(p), 30'(i));
						if (reads_seen == fail_at) begin
							queue_item(OP_ADVANCE, $urandom, $urandom,
								good ^ (32'd1 << $urandom_range(31)));
							return;
						end
						reads_seen++;
						queue_item(OP_ADVANCE, $urandom, $urandom, good);
					end
				end
			end
		end
	endtask

	always @(negedge clk) begin : sender
		req_t nxt;
		if (arst_n && (!s_tvalid || in_taken)) begin
			if (pending_items.size() != 0 &&
					(calm || hold_left != 0 || $urandom_range(99) >= 22)) begin
				nxt = pending_items.pop_front();
				s_tuser <= nxt.opcode;
				s_tdata <= {nxt.read_data, nxt.byte_count, nxt.base_address};
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : receiver
		if (arst_n) begin
			if (!holdoff_done && items_in >= HOLD_AT) begin
				holdoff_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				m_tready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else if (calm) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= 22);
			end
		end
	end

	always @(posedge clk) begin : monitor
		res_t want;
		if (arst_n) begin
			in_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				items_in <= items_in + 1;
				step_sequencer(s_tuser, s_tdata);
			end
			if (m_tvalid && m_tready) begin
				if (expected_accesses.size() == 0) begin
					flag_mismatch("unexpected item", {30'd0, m_tuser}, 32'd0);
				end else begin
					want = expected_accesses.pop_front();
					if (m_tuser !== want.access_kind)
						flag_mismatch("access_kind", {30'd0, m_tuser}, {30'd0, want.access_kind});
					if (m_tdata[31:0] !== want.access_address)
						flag_mismatch("access_address", m_tdata[31:0], want.access_address);
					if (m_tdata[63:32] !== want.write_data)
						flag_mismatch("write_data", m_tdata[63:32], want.write_data);
					if (m_tdata[64] !== want.test_passed)
						flag_mismatch("test_passed", {31'd0, m_tdata[64]}, {31'd0, want.test_passed});
					if (m_tdata[71:65] !== 7'd0)
						flag_mismatch("tdata padding", {25'd0, m_tdata[71:65]}, 32'd0);
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("%0t: timeout, no item moved for %0d cycles", $realtime, quiet_cycles);
					$display("Simulation FAILED");
					$finish;
				end
			end
		end
	end

	initial begin : stimulus
		int          pick;
		int          words;
		int          fail_at;
		int          noise;
		logic [31:0] base;
		logic [31:0] bytes;
		bit          gen_idle;

		queue_item(OP_START, 32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000);
		queue_item(OP_START, 32'h0000_0000, 32'd3, 32'hffff_ffff);
		queue_item(OP_START, 32'h0000_1000, 32'd0, 32'h0000_0000);
		queue_item(OP_ADVANCE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		plan_test(32'h0000_0000, 32'hffff_ffff, -1, 2);
		plan_test(32'hffff_fffc, 32'd7, -1, -1);
		plan_test(32'h0000_0040, 32'd4, 0, -1);
		queue_item(OP_ADVANCE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);

		gen_idle = 1'b1;
		while (planned < ITEM_GOAL) begin
			pick = $urandom_range(99);
			if (pick < 60) begin
				words = (pick < 6) ? $urandom_range(16, 5) : $urandom_range(4, 1);
				base = ($urandom_range(9) == 0) ? 32'hffff_fff0 : ($urandom & 32'hffff_fffc);
				bytes = words * 4 + $urandom_range(3);
				fail_at = ($urandom_range(3) == 0) ? $urandom_range(5 * words - 1) : -1;
				plan_test(base, bytes, fail_at, -1);
				gen_idle = 1'b1;
			end else if (pick < 72) begin
				if ($urandom_range(1) == 0) begin
					base = $urandom;
					if (base[1:0] == 2'b00)
						base[0] = 1'b1;
					queue_item(OP_START, base, $urandom, $urandom);
				end else begin
					queue_item(OP_START, $urandom, $urandom_range(3), $urandom);
				end
				gen_idle = 1'b1;
			end else if (pick < 85) begin
				bytes = $urandom;
				if (bytes < MIN_BYTES)
					bytes = MIN_BYTES;
				plan_test($urandom & 32'hffff_fffc, bytes, -1, $urandom_range(6, 1));
				gen_idle = 1'b0;
			end else if (gen_idle) begin
				noise = $urandom_range(3, 1);
				repeat (noise) queue_item(OP_ADVANCE, $urandom, $urandom, $urandom, 1'b0);
			end
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_items.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_accesses.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
